@@ src/cbif_pkg.sv @@
`default_nettype none

package cbif_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W     = 64;
    localparam int OUT_W     = 16;

    localparam logic [7:0] MT_MASK = 8'he0;
    localparam logic [7:0] AI_MASK = 8'h1f;

    localparam logic [4:0] AI_ARG1 = 5'd24;
    localparam logic [4:0] AI_ARG2 = 5'd25;
    localparam logic [4:0] AI_ARG4 = 5'd26;
    localparam logic [4:0] AI_ARG8 = 5'd27;

    localparam logic [2:0] MT_BSTR  = 3'd2;
    localparam logic [2:0] MT_TSTR  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;
    localparam logic [2:0] MT_TAG   = 3'd6;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_RESERVED = 2'd1,
        ERR_DEEP     = 2'd2,
        ERR_MAP_BIG  = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        ROLE_HEAD    = 2'd0,
        ROLE_ARG     = 2'd1,
        ROLE_PAYLOAD = 2'd2
    } t_role;

    typedef struct packed {
        logic       item_end;
        t_err       error_code;
        t_role      byte_role;
        logic [4:0] nest_depth;
    } t_result;

endpackage

`default_nettype wire

@@ src/cbif_core.sv @@
`default_nettype none

module cbif_core
    import cbif_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_byte,
    output t_result         o_result
);

    logic [CNT_W-1:0] r_stack [MAX_DEPTH];
    logic [LVL_W-1:0] r_level, n_level;
    logic [CNT_W-1:0] r_remain, n_remain;
    logic             r_in_head, n_in_head;
    logic [2:0]       r_type, n_type;
    logic [CNT_W-1:0] r_value, n_value;

    logic [2:0]       major;
    logic [4:0]       ai;
    logic [LVL_W-1:0] top_pos;
    logic [LVL_W-1:0] lvl;
    logic [CNT_W-1:0] top;
    logic [CNT_W-1:0] dec;
    logic             zero;
    logic             do_head;
    logic [2:0]       h_type;
    logic [CNT_W-1:0] h_val;
    logic             is_leaf, is_str, is_nest;
    logic [CNT_W-1:0] nest_n;
    logic             dec_en, set_en;
    logic [IDX_W-1:0] dec_idx, set_idx;
    logic [CNT_W-1:0] set_data;
    logic             ended;
    t_err             err;
    t_role            role;

    assign major   = 3'((i_byte & MT_MASK) >> 5);
    assign ai      = 5'(i_byte & AI_MASK);
    assign top_pos = r_level - LVL_W'(1);

    always_comb begin
        n_level   = r_level;
        n_remain  = r_remain;
        n_in_head = r_in_head;
        n_type    = r_type;
        n_value   = r_value;
        lvl       = r_level;
        top       = r_stack[top_pos[IDX_W-1:0]];
        do_head   = 1'b0;
        h_type    = r_type;
        h_val     = r_value;
        ended     = 1'b0;
        err       = ERR_NONE;
        role      = ROLE_HEAD;
        dec_en    = 1'b0;
        set_en    = 1'b0;
        set_idx   = '0;
        set_data  = '0;
        is_leaf   = 1'b0;
        is_str    = 1'b0;
        is_nest   = 1'b0;
        nest_n    = '0;

        if (r_in_head) begin
            role     = ROLE_ARG;
            n_value  = {r_value[CNT_W-9:0], i_byte};
            n_remain = (r_remain != '0) ? r_remain - CNT_W'(1) : '0;
            if (n_remain == '0) begin
                n_in_head = 1'b0;
                do_head   = 1'b1;
                h_val     = n_value;
            end
        end else if (r_remain != '0) begin
            role     = ROLE_PAYLOAD;
            n_remain = r_remain - CNT_W'(1);
            ended    = (n_remain == '0) && (r_level == '0);
        end else begin
            role = ROLE_HEAD;
            // open a new top-level item with one child due
            if (r_level == '0) begin
                lvl      = LVL_W'(1);
                top      = CNT_W'(1);
                n_level  = LVL_W'(1);
                set_en   = 1'b1;
                set_idx  = '0;
                set_data = CNT_W'(1);
            end
            n_type  = major;
            n_value = '0;
            h_type  = major;
            if (ai < AI_ARG1) begin
                n_value = CNT_W'(ai);
                h_val   = CNT_W'(ai);
                do_head = 1'b1;
            end else if (ai <= AI_ARG8) begin
                n_in_head = 1'b1;
                n_remain  = CNT_W'(1) << ai[1:0];
            end else begin
                err = ERR_RESERVED;
            end
        end

        dec     = top - CNT_W'(1);
        zero    = (lvl != '0) && (dec == '0);
        dec_idx = IDX_W'(lvl - LVL_W'(1));

        if (do_head) begin
            case (h_type)
                MT_BSTR, MT_TSTR: begin
                    is_leaf = (h_val == '0);
                    is_str  = (h_val != '0);
                end
                MT_ARRAY: begin
                    is_leaf = (h_val == '0);
                    is_nest = (h_val != '0);
                    nest_n  = h_val;
                end
                MT_MAP: begin
                    if (h_val[CNT_W-1]) begin
                        err = ERR_MAP_BIG;
                    end else begin
                        is_leaf = (h_val == '0);
                        is_nest = (h_val != '0);
                        nest_n  = {h_val[CNT_W-2:0], 1'b0};
                    end
                end
                MT_TAG: begin
                    is_nest = 1'b1;
                    nest_n  = CNT_W'(1);
                end
                default: begin
                    is_leaf = 1'b1;
                end
            endcase

            dec_en = (lvl != '0) && (is_leaf || is_str || is_nest);

            if (is_leaf || is_str) begin
                n_level = zero ? lvl - LVL_W'(1) : lvl;
                if (is_leaf) begin
                    ended = (n_level == '0);
                end else begin
                    n_remain = h_val;
                end
            end else if (is_nest) begin
                if (zero) begin
                    // exhausted parent is replaced by the child
                    set_en   = 1'b1;
                    set_idx  = dec_idx;
                    set_data = nest_n;
                    n_level  = lvl;
                end else if (lvl >= LVL_W'(MAX_DEPTH)) begin
                    err = ERR_DEEP;
                end else begin
                    set_en   = 1'b1;
                    set_idx  = lvl[IDX_W-1:0];
                    set_data = nest_n;
                    n_level  = lvl + LVL_W'(1);
                end
            end
        end

        if (err != ERR_NONE) begin
            n_level   = '0;
            n_remain  = '0;
            n_in_head = 1'b0;
            n_type    = '0;
            n_value   = '0;
            ended     = 1'b0;
            dec_en    = 1'b0;
            set_en    = 1'b0;
        end

        o_result.item_end   = ended;
        o_result.error_code = err;
        o_result.byte_role  = role;
        o_result.nest_depth = 5'(n_level);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_remain  <= '0;
            r_in_head <= 1'b0;
            r_type    <= '0;
            r_value   <= '0;
        end else if (i_advance) begin
            r_level   <= n_level;
            r_remain  <= n_remain;
            r_in_head <= n_in_head;
            r_type    <= n_type;
            r_value   <= n_value;
        end
    end

    // A write of a new count takes precedence over the decrement of the same entry.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
                if (set_en && set_idx == IDX_W'(i)) begin
                    r_stack[i] <= set_data;
                end else if (dec_en && dec_idx == IDX_W'(i)) begin
                    r_stack[i] <= dec;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ src/cbor_item_boundary_finder.sv @@
// CBOR item boundary finder: takes a CBOR byte stream one byte per
// transaction and returns one result per byte, with tlast high on the byte
// that completes a top-level data item. Each result also carries an error
// code, the role of the byte (head, argument, string payload) and the number
// of open nesting levels after it. Reserved additional info, nesting deeper
// than the stack and oversized maps raise an error and drop the decoder back
// to idle, so the next byte starts a new item. Throughput is one byte per
// clock while the receiver does not stall; a byte is held in the input
// register, then its result in the result register. Each byte's update of
// the top stack count is one 64-bit decrement and zero test plus the
// push/replace/pop selection between the input and result registers.
`default_nettype none

module cbor_item_boundary_finder
    import cbif_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [7:0]       i_s_tdata,   // [7:0] data_byte
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata,   // [1:0] error_code, [3:2] byte_role,
                                               // [8:4] nest_depth, rest zero
    output logic                  o_m_tlast    // item_end
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;
    t_result    step_res;
    logic       advance;

    // Process the held byte when the result register is free or draining.
    assign advance    = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Capture payloads; hold them while stalled.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

    cbif_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (step_res)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tlast  = r_out.item_end;
    assign o_m_tdata  = OUT_W'({r_out.nest_depth, r_out.byte_role, r_out.error_code});

endmodule

`default_nettype wire

@@ src/cbif_checker.sv @@
`default_nettype none

module cbif_checker
    import cbif_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_tvalid,
    input wire logic             o_s_tready,
    input wire logic [7:0]       i_s_tdata,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata,
    input wire logic             o_m_tlast
);

    logic [1:0] err_f;
    logic [4:0] depth_f;

    assign err_f   = o_m_tdata[1:0];
    assign depth_f = o_m_tdata[8:4];

    // an item can only close once every level is gone
    a_end_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> depth_f == 5'd0 && err_f == ERR_NONE)
        else $error("item end with open levels or error");

    // an error drops the decoder to idle
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && err_f != ERR_NONE |-> depth_f == 5'd0 && !o_m_tlast)
        else $error("error result shows open levels or end");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind cbor_item_boundary_finder cbif_checker u_checker (.*);

`default_nettype wire

@@ sim/cbif_boundary_checker.sv @@
module cbif_boundary_checker
    import cbif_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_s_tready,
    input  wire logic [7:0]       i_s_tdata,   // [7:0] data_byte
    input  wire logic             i_m_tvalid,
    input  wire logic             i_m_tready,
    input  wire logic [OUT_W-1:0] i_m_tdata,   // [1:0] error_code, [3:2] byte_role,
                                               // [8:4] nest_depth, rest zero
    input  wire logic             i_m_tlast,   // item_end
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOWN_MISSES = 10;

    // Shadow of the framer: child counts per open level and the head in progress.
    logic [CNT_W-1:0] lvl_cnt [MAX_DEPTH];
    logic [LVL_W-1:0] open_lvls;
    logic [CNT_W-1:0] bytes_due;
    logic             arg_phase;
    logic [2:0]       head_major;
    logic [CNT_W-1:0] head_arg;
    logic             item_done;

    t_result due_results[$];
    int      miss_count = 0;
    int      result_no  = 0;

    function automatic void clear_parse();
        open_lvls  = '0;
        bytes_due  = '0;
        arg_phase  = 1'b0;
        head_major = '0;
        head_arg   = '0;
    endfunction

    // Count one child off the top level; true when that level is used up.
    function automatic logic take_child();
        if (open_lvls == 0 || open_lvls > MAX_DEPTH)
            return 1'b0;
        lvl_cnt[open_lvls - 1] = lvl_cnt[open_lvls - 1] - 1;
        return lvl_cnt[open_lvls - 1] == 0;
    endfunction

    function automatic t_err close_leaf();
        if (take_child())
            open_lvls = open_lvls - 1;
        if (open_lvls == 0)
            item_done = 1'b1;
        return ERR_NONE;
    endfunction

    // A used-up parent is overwritten by the new level instead of pushing.
    function automatic t_err open_level(input logic [CNT_W-1:0] kids);
        if (take_child()) begin
            lvl_cnt[open_lvls - 1] = kids;
            return ERR_NONE;
        end
        if (open_lvls >= MAX_DEPTH)
            return ERR_DEEP;
        lvl_cnt[open_lvls] = kids;
        open_lvls = open_lvls + 1;
        return ERR_NONE;
    endfunction

    function automatic t_err finish_head(input logic [2:0] major, input logic [CNT_W-1:0] arg);
        case (major)
            MT_BSTR, MT_TSTR: begin
                if (arg == 0)
                    return close_leaf();
                if (take_child())
                    open_lvls = open_lvls - 1;
                bytes_due = arg;
                return ERR_NONE;
            end
            MT_ARRAY: begin
                if (arg == 0)
                    return close_leaf();
                return open_level(arg);
            end
            MT_MAP: begin
                if (arg[CNT_W-1])
                    return ERR_MAP_BIG;
                if (arg == 0)
                    return close_leaf();
                return open_level(arg << 1);
            end
            MT_TAG: begin
                return open_level(1);
            end
            default: begin
                return close_leaf();
            end
        endcase
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b);
        t_result    r;
        t_err       err;
        t_role      role;
        logic [4:0] ai;
        err       = ERR_NONE;
        item_done = 1'b0;
        ai        = b[4:0];
        if (arg_phase) begin
            role     = ROLE_ARG;
            head_arg = {head_arg[CNT_W-9:0], b};
            if (bytes_due != 0)
                bytes_due = bytes_due - 1;
            if (bytes_due == 0) begin
                arg_phase = 1'b0;
                err       = finish_head(head_major, head_arg);
            end
        end else if (bytes_due != 0) begin
            role      = ROLE_PAYLOAD;
            bytes_due = bytes_due - 1;
            if (bytes_due == 0 && open_lvls == 0)
                item_done = 1'b1;
        end else begin
            role = ROLE_HEAD;
            if (open_lvls == 0) begin
                lvl_cnt[0] = 1;
                open_lvls  = 1;
            end
            head_major = b[7:5];
            head_arg   = '0;
            if (ai < AI_ARG1) begin
                head_arg = CNT_W'(ai);
                err      = finish_head(head_major, head_arg);
            end else if (ai <= AI_ARG8) begin
                arg_phase = 1'b1;
                bytes_due = CNT_W'(1) << (ai - AI_ARG1);
            end else begin
                err = ERR_RESERVED;
            end
        end
        if (err != ERR_NONE) begin
            clear_parse();
            item_done = 1'b0;
        end
        r.item_end   = item_done;
        r.error_code = err;
        r.byte_role  = role;
        r.nest_depth = 5'(open_lvls);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DEPTH; i++)
                lvl_cnt[i] = '0;
            clear_parse();
            due_results.delete();
            result_no = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                due_results.insert(due_results.size(), decode_byte(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    miss_count++;
                    if (miss_count <= SHOWN_MISSES)
                        $display("result %0d: none expected, got last=%0b tdata=%h",
                                 result_no, i_m_tlast, i_m_tdata);
                end else begin
                    want = due_results.pop_front();
                    if (i_m_tlast !== want.item_end
                            || i_m_tdata[1:0] !== want.error_code
                            || i_m_tdata[3:2] !== want.byte_role
                            || i_m_tdata[8:4] !== want.nest_depth
                            || i_m_tdata[OUT_W-1:9] !== '0) begin
                        miss_count++;
                        if (miss_count <= SHOWN_MISSES) begin
                            $display("result %0d: expected last=%0b err=%0d role=%0d depth=%0d",
                                     result_no, want.item_end, want.error_code,
                                     want.byte_role, want.nest_depth);
                            $display("    got last=%0b err=%0d role=%0d depth=%0d pad=%h",
                                     i_m_tlast, i_m_tdata[1:0], i_m_tdata[3:2],
                                     i_m_tdata[8:4], i_m_tdata[OUT_W-1:9]);
                        end
                    end
                end
                result_no++;
            end
        end
        o_fail_count <= miss_count;
        o_pending    <= due_results.size();
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import cbif_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL     = 1250;
    localparam int RESET_CYCLES  = 11;
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off, fills the pipeline
    localparam int DRAIN_CYCLES  = 20;     // extra wait once no result is pending
    localparam int TIME_LIMIT_NS = 400_000;

    // Major types and additional-info codes the package does not name.
    localparam logic [2:0] MT_UINT    = 3'd0;
    localparam logic [2:0] MT_NINT    = 3'd1;
    localparam logic [2:0] MT_SIMPLE  = 3'd7;
    localparam logic [4:0] AI_RESV_LO = 5'd28;
    localparam logic [4:0] AI_BREAK   = 5'd31;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata;       // [7:0] data_byte
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;       // [1:0] error_code, [3:2] byte_role, [8:4] nest_depth
    logic             o_m_tlast;       // item_end

    int fail_count;
    int pending;

    // Idle odds in percent per cycle; the stimulus thread changes them per phase.
    int send_idle_pct = 16;
    int recv_idle_pct = 70;
    int hold_ticket   = 0;
    int sent_bytes    = 0;

    logic [7:0] stim_q[$];

    always #1 i_clk = ~i_clk;

    cbor_item_boundary_finder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    cbif_boundary_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Append one byte to the stimulus stream.
    function automatic void add_byte(input logic [7:0] b);
        stim_q.insert(stim_q.size(), b);
    endfunction

    // Random byte for argument and payload content. Wide string-length heads are
    // folded to a one-byte length, so a byte that lands on a head position after
    // a misaligned parse can never open a string that swallows the rest of the run.
    function automatic logic [7:0] safe_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ((b[7:5] == MT_BSTR || b[7:5] == MT_TSTR) && b[4:0] > AI_ARG1
                && b[4:0] <= AI_ARG8)
            b[4:0] = AI_ARG1;
        return b;
    endfunction

    // Argument size in bytes: 0 means the value sits in the head itself.
    function automatic int rand_width();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 4;
            default: return 8;
        endcase
    endfunction

    function automatic logic [63:0] rand_value(input int width);
        logic [63:0] v;
        if (width == 0)
            return 64'($urandom_range(0, 23));
        v = '0;
        repeat (width) v = {v[55:0], safe_byte()};
        return v;
    endfunction

    // Pick an encoding that holds v, sometimes wider than needed (leading zeros).
    function automatic int fit_width(input logic [63:0] v);
        int w;
        if (v < 24 && $urandom_range(0, 2) != 0)
            return 0;
        w = (v < 64'd256) ? 1 : (v < 64'd65536) ? 2 : (v < 64'h1_0000_0000) ? 4 : 8;
        while (w < 8 && $urandom_range(0, 3) == 0)
            w = 2 * w;
        return w;
    endfunction

    // Append a head: major type, then the argument big-endian in arg_len bytes.
    task automatic put_head(input logic [2:0] major, input logic [63:0] arg,
                            input int arg_len);
        logic [4:0] ai;
        case (arg_len)
            0:       ai = arg[4:0];
            1:       ai = AI_ARG1;
            2:       ai = AI_ARG2;
            4:       ai = AI_ARG4;
            default: ai = AI_ARG8;
        endcase
        add_byte({major, ai});
        for (int i = arg_len - 1; i >= 0; i--)
            add_byte(arg[8*i +: 8]);
    endtask

    // Append one complete, well-formed item. Open containers are tracked by their
    // remaining child counts; narrow keeps string lengths to a single byte.
    task automatic gen_item(input int max_nest, input bit narrow);
        int         open_kids[$];
        int         k;
        int         w;
        int         len;
        logic [2:0] major;
        open_kids.insert(open_kids.size(), 1);
        while (open_kids.size() > 0) begin
            open_kids[open_kids.size() - 1] = open_kids[open_kids.size() - 1] - 1;
            k = $urandom_range(0, 9);
            if (k >= 7 && open_kids.size() <= max_nest) begin
                if (k == 9) begin
                    w = rand_width();
                    put_head(MT_TAG, rand_value(w), w);
                    open_kids.insert(open_kids.size(), 1);
                end else begin
                    major = (k == 7) ? MT_ARRAY : MT_MAP;
                    len   = (k == 7) ? $urandom_range(0, 3) : $urandom_range(0, 2);
                    put_head(major, 64'(len), fit_width(64'(len)));
                    if (len != 0)
                        open_kids.insert(open_kids.size(),
                                         (major == MT_MAP) ? 2 * len : len);
                end
            end else if (k >= 4) begin
                major = k[0] ? MT_BSTR : MT_TSTR;
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 40)
                                                    : $urandom_range(0, 5);
                w     = narrow ? ((len < 24) ? 0 : 1) : fit_width(64'(len));
                put_head(major, 64'(len), w);
                repeat (len) add_byte(safe_byte());
            end else begin
                major = (k == 0) ? MT_NINT : (k == 1) ? MT_SIMPLE : MT_UINT;
                w     = rand_width();
                put_head(major, rand_value(w), w);
            end
            while (open_kids.size() > 0 && open_kids[open_kids.size() - 1] == 0)
                open_kids.delete(open_kids.size() - 1);
        end
    endtask

    // Offer one byte and hold it until the transaction completes.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_all();
        while (stim_q.size() > 0)
            send_byte(stim_q.pop_front());
    endtask

    // Receiver: random back-pressure, plus one long hold-off per ticket.
    initial begin
        int hold_served;
        hold_served = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus: reset, a directed walk over the special cases, then random traffic.
    initial begin
        int          phase;
        int          sel;
        int          cut;
        logic [63:0] v;
        phase = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_head(MT_UINT, 0, 0);                      // all-zero byte, complete item
        add_byte({MT_SIMPLE, AI_BREAK});              // all-ones byte: reserved info
        put_head(MT_BSTR, 0, 0);                      // zero-length string ends at its head
        put_head(MT_TSTR, 1, 0);                      // one payload byte
        add_byte(8'h7a);
        put_head(MT_MAP, 0, 0);                       // empty container is a leaf
        put_head(MT_MAP, 1, 0);                       // one key/value pair
        put_head(MT_UINT, 1, 0);
        put_head(MT_UINT, 2, 0);
        put_head(MT_ARRAY, 2, 0);                     // array holding a tagged value
        put_head(MT_TAG, 6, 0);
        put_head(MT_UINT, 255, 1);
        put_head(MT_NINT, 0, 0);
        put_head(MT_SIMPLE, 20, 0);
        put_head(MT_MAP, 64'h8000_0000_0000_0000, 8); // smallest map count that is too large
        send_all();

        while (sent_bytes < ITEM_GOAL) begin
            // Three idle regimes: sender light/receiver heavy, swapped, then none,
            // opening the last one with a long receiver hold-off.
            if (phase == 0 && sent_bytes >= ITEM_GOAL / 3) begin
                phase         = 1;
                send_idle_pct = 70;
                recv_idle_pct = 16;
            end else if (phase == 1 && sent_bytes >= 2 * ITEM_GOAL / 3) begin
                phase         = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_ticket++;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                gen_item($urandom_range(0, 3), 1'b0);
            end else if (sel < 76) begin
                // Fill the stack to its limit, then either overflow it or close it out.
                repeat (MAX_DEPTH) put_head(MT_ARRAY, 2, 0);
                if ($urandom_range(0, 1))
                    put_head(MT_ARRAY, 2, 0);
                else
                    repeat (MAX_DEPTH + 1) gen_item($urandom_range(0, 1), 1'b0);
            end else if (sel < 81) begin
                // Map count at or above the limit, or just below it; a break byte clears the latter.
                v = rand_value(8);
                if ($urandom_range(0, 1)) begin
                    v[63] = 1'b1;
                    put_head(MT_MAP, v, 8);
                end else begin
                    put_head(MT_MAP, 64'h7fff_ffff_ffff_ffff, 8);
                    add_byte({MT_SIMPLE, AI_BREAK});
                end
            end else if (sel < 90) begin
                // Cut an item short and drop a reserved head where it broke off.
                gen_item($urandom_range(0, 3), 1'b1);
                cut = $urandom_range(0, stim_q.size() - 1);
                while (stim_q.size() > cut)
                    stim_q.delete(stim_q.size() - 1);
                add_byte({3'($urandom), 5'($urandom_range(AI_RESV_LO, AI_BREAK))});
            end else begin
                repeat ($urandom_range(1, 8)) add_byte(safe_byte());
            end
            send_all();
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(TIME_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
src/cbif_pkg.sv
src/cbif_core.sv
src/cbor_item_boundary_finder.sv
src/cbif_checker.sv
sim/cbif_boundary_checker.sv
sim/tb_top.sv
